// File: rtl/gtq_pkg.sv
`timescale 1ns / 1ps
package gtq_pkg;
    localparam int SLOT_W  = 8;
    localparam int GROUP_W = 6;
    localparam int TAG_W   = 16;
    localparam int IDX_W   = 16;
    localparam int EXIT_W  = 17;
    localparam int ITEM_SLOTS  = 1 << SLOT_W;
    localparam int GROUP_COUNT = 1 << GROUP_W;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_DEPART = 2'd1;
    localparam logic [1:0] KIND_FULL   = 2'd2;
    localparam logic [1:0] KIND_EMPTY  = 2'd3;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    localparam logic [EXIT_W-1:0] EXIT_START = EXIT_W'(2);
    localparam logic [EXIT_W-1:0] EXIT_STEP  = EXIT_W'(2);

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [GROUP_W-1:0] group;
        logic [IDX_W-1:0]   entry;
    } slot_t;
endpackage

// File: rtl/grouped_team_queue.sv
`timescale 1ns / 1ps
// channel | dir | tdata fields (lsb first)                               | tuser
// s_      | in  | operation[0], group_id[6:1], item_tag[22:7], pad to 24   | -
// m_      | out | kind[1:0], out_tag[17:2], out_group[23:18],
//         |     | entry_index[39:24], exit_time[56:40], pad to 64          | -
//
// one word in, one word out, one at a time. a plain arrival reads the group pointers and
// the free ring, writes the slot and link, then gives its result word; an arrival whose
// index is even and non-zero adds a departure pass, a drain is a departure pass alone, and
// a dropped arrival answers straight from idle. the pass is a chain of reads: active ring front, group
// pointers, then the slot record and link. s_tready is low while a word is in work or the
// output register holds a word, so a low m_tready holds off the next word. reset is
// synchronous; the free slot ring needs no clearing, unwritten entries stand for their own
// slot number (tracked by a fill count). m_tvalid holds until taken.
module grouped_team_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // operation, group_id, item_tag
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // kind, out_tag, out_group, entry_index, exit_time
);
    import gtq_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ARD  = 3'd1; // group pointer reads back, free ring read back
    localparam logic [2:0] ST_AWR  = 3'd2; // choose departure pass or plain result
    localparam logic [2:0] ST_DRD  = 3'd3; // read active ring front
    localparam logic [2:0] ST_DGR  = 3'd4; // read group pointers
    localparam logic [2:0] ST_DSL  = 3'd5; // read slot record and link
    localparam logic [2:0] ST_DFIN = 3'd6; // report and update
    localparam logic [2:0] ST_OUT  = 3'd7;

    // memories
    slot_t              slot_mem  [ITEM_SLOTS];
    logic [SLOT_W-1:0]  link_mem  [ITEM_SLOTS];
    logic [SLOT_W-1:0]  free_mem  [ITEM_SLOTS];
    logic [SLOT_W-1:0]  first_mem [GROUP_COUNT];
    logic [SLOT_W-1:0]  last_mem  [GROUP_COUNT];
    logic [GROUP_W-1:0] act_mem   [GROUP_COUNT];
    logic [GROUP_COUNT-1:0] waiting_reg;

    logic [2:0]         state_reg;
    logic [SLOT_W-1:0]  free_front_reg, free_back_reg;
    logic [SLOT_W:0]    occ_reg;
    logic [SLOT_W:0]    fill_reg;      // ring entries written since reset
    logic [GROUP_W-1:0] act_front_reg, act_back_reg;
    logic [IDX_W-1:0]   arr_reg;
    logic [EXIT_W-1:0]  exit_reg;
    logic               out_valid_reg;
    logic [63:0]        out_data_reg;

    logic [GROUP_W-1:0] g_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic               dep_reg;
    logic               op_reg;

    // registered read data
    logic [SLOT_W-1:0]  free_rd, first_rd, last_rd, link_rd;
    logic [GROUP_W-1:0] act_rd;
    slot_t              slot_rd;
    logic [SLOT_W-1:0]  free_addr_reg;
    logic [SLOT_W-1:0]  first_addr, last_addr_rd;
    logic [GROUP_W-1:0] grp_raddr;
    logic [SLOT_W-1:0]  slot_raddr;

    logic               take;
    logic [SLOT_W-1:0]  new_slot;
    logic [IDX_W-1:0]   idx_next;

    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign take     = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign idx_next = arr_reg + IDX_W'(1);

    // untouched ring entries still hold their own slot number
    assign new_slot = ({1'b0, free_addr_reg} < fill_reg) ? free_rd : free_addr_reg;

    // group pointers follow the incoming word when idle, else the active ring front
    always_comb begin
        grp_raddr = (state_reg == ST_IDLE) ? s_tdata[6:1] : act_rd;
        slot_raddr = first_rd;
    end
    assign first_addr   = first_rd;
    assign last_addr_rd = last_rd;

    always_ff @(posedge aclk) begin
        free_rd  <= free_mem[free_front_reg];
        act_rd   <= act_mem[act_front_reg];
        first_rd <= first_mem[grp_raddr];
        last_rd  <= last_mem[grp_raddr];
        slot_rd  <= slot_mem[slot_raddr];
        link_rd  <= link_mem[slot_raddr];
        free_addr_reg <= free_front_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            waiting_reg    <= '0;
            free_front_reg <= '0;
            free_back_reg  <= '0;
            occ_reg        <= '0;
            fill_reg       <= '0;
            act_front_reg  <= '0;
            act_back_reg   <= '0;
            arr_reg        <= '0;
            exit_reg       <= EXIT_START;
            out_valid_reg  <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (take) begin
                        g_reg   <= s_tdata[6:1];
                        tag_reg <= s_tdata[22:7];
                        op_reg  <= s_tdata[0];
                        if (s_tdata[0] == OP_DRAIN) begin
                            dep_reg   <= 1'b1;
                            state_reg <= ST_DRD;
                        end else if (occ_reg[SLOT_W]) begin
                            out_data_reg  <= {62'd0, KIND_FULL};
                            out_valid_reg <= 1'b1;
                        end else begin
                            dep_reg   <= !arr_reg[0] && (arr_reg != '0);
                            state_reg <= ST_ARD;
                        end
                    end
                end
                ST_ARD: begin
                    slot_mem[new_slot] <= '{tag: tag_reg, group: g_reg, entry: arr_reg};
                    free_front_reg <= free_front_reg + SLOT_W'(1);
                    occ_reg        <= occ_reg + (SLOT_W+1)'(1);
                    arr_reg        <= idx_next;
                    if (waiting_reg[g_reg]) begin
                        link_mem[last_addr_rd] <= new_slot;
                    end else begin
                        waiting_reg[g_reg]    <= 1'b1;
                        first_mem[g_reg]      <= new_slot;
                        act_mem[act_back_reg] <= g_reg;
                        act_back_reg          <= act_back_reg + GROUP_W'(1);
                    end
                    last_mem[g_reg] <= new_slot;
                    state_reg <= ST_AWR;
                end
                ST_AWR: begin
                    if (dep_reg) begin
                        state_reg <= ST_DRD;
                    end else begin
                        out_data_reg  <= {62'd0, KIND_NONE};
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_DRD: state_reg <= ST_DGR;   // act_rd now valid next cycle
                ST_DGR: state_reg <= ST_DSL;
                ST_DSL: state_reg <= ST_DFIN;
                ST_DFIN: begin
                    if (occ_reg == '0 || !waiting_reg[act_rd]) begin
                        // nothing to take: a drain reports empty, an arrival plain
                        out_data_reg <= {62'd0, (op_reg == OP_DRAIN) ? KIND_EMPTY : KIND_NONE};
                    end else begin
                        out_data_reg <= {7'd0, exit_reg, slot_rd.entry, slot_rd.group,
                                         slot_rd.tag, KIND_DEPART};
                        exit_reg <= exit_reg + EXIT_STEP;
                        if (first_addr == last_addr_rd) begin
                            waiting_reg[act_rd] <= 1'b0;
                            act_front_reg <= act_front_reg + GROUP_W'(1);
                        end else begin
                            first_mem[act_rd] <= link_rd;
                        end
                        free_mem[free_back_reg] <= first_addr;
                        free_back_reg <= free_back_reg + SLOT_W'(1);
                        if (!fill_reg[SLOT_W]) fill_reg <= fill_reg + (SLOT_W+1)'(1);
                        occ_reg <= occ_reg - (SLOT_W+1)'(1);
                    end
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_OUT;
                end
                ST_OUT: state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
